### design/dskc_pkg.sv
// Shared types, codes and the base decoder for the dual-strand k-mer counter.
// No dependencies; every other design file but dskc_ram imports this package.
`default_nettype none

package dskc_pkg;

    // Widths fixed by the interface
    localparam int CHAR_BITS   = 8;
    localparam int INDEX_BITS  = 12;
    localparam int OUT_BITS    = 32;
    localparam int OPCODE_BITS = 2;

    // Depth of the command queue between the front and the back part
    localparam int QUEUE_DEPTH = 2;

    // Input opcodes
    typedef enum logic [OPCODE_BITS-1:0] {
        OP_CHAR   = 2'd0,
        OP_RECORD = 2'd1,
        OP_READ   = 2'd2
    } t_opcode;

    // Kind of a queued command
    typedef enum logic {
        CMD_COUNT = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd;

    // Back part sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD1,
        S_UPD2,
        S_RDOUT
    } t_back_state;

    // Character codes
    localparam logic [CHAR_BITS-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_T    = 8'h54;
    localparam logic [CHAR_BITS-1:0] CHAR_C    = 8'h43;
    localparam logic [CHAR_BITS-1:0] CHAR_G    = 8'h47;
    localparam logic [CHAR_BITS-1:0] CHAR_A_LC = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_T_LC = 8'h74;
    localparam logic [CHAR_BITS-1:0] CHAR_C_LC = 8'h63;
    localparam logic [CHAR_BITS-1:0] CHAR_G_LC = 8'h67;

    // Base codes; complement flips the low bit (A<->T, C<->G)
    localparam logic [1:0] BASE_A    = 2'd0;
    localparam logic [1:0] BASE_T    = 2'd1;
    localparam logic [1:0] BASE_C    = 2'd2;
    localparam logic [1:0] BASE_G    = 2'd3;
    localparam logic [1:0] BASE_COMP = 2'd1;

    typedef struct packed {
        logic       hit;
        logic [1:0] code;
    } t_base;

    function automatic t_base base_decode(input logic [CHAR_BITS-1:0] c);
        t_base b;
        b.hit  = 1'b1;
        b.code = BASE_A;
        case (c) inside
            CHAR_A, CHAR_A_LC: b.code = BASE_A;
            CHAR_T, CHAR_T_LC: b.code = BASE_T;
            CHAR_C, CHAR_C_LC: b.code = BASE_C;
            CHAR_G, CHAR_G_LC: b.code = BASE_G;
            default:           b.hit  = 1'b0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### design/dskc_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module dskc_ram #(
    parameter int DATA_BITS = 32,
    parameter int ADDR_BITS = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [DATA_BITS-1:0] i_wdata,
    input  wire logic [ADDR_BITS-1:0] i_raddr_a,
    input  wire logic [ADDR_BITS-1:0] i_raddr_b,
    output logic      [DATA_BITS-1:0] o_rdata_a,
    output logic      [DATA_BITS-1:0] o_rdata_b
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

### design/dskc_queue.sv
// Short command queue between the front and the back part.
// Depends on dskc_pkg for its depth.
`default_nettype none

module dskc_queue #(
    parameter int WIDTH = 25
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_entry,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_head
);

    import dskc_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(QUEUE_DEPTH);

    logic [WIDTH-1:0]    r_slot [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != FULL_CNT) || i_pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");

endmodule

`default_nettype wire

### design/dskc_front.sv
// Front part: accepts words, keeps both strand windows and queues commands.
// Depends on dskc_pkg for opcodes, command kinds and the base decoder.
`default_nettype none

module dskc_front #(
    parameter int KMER_LENGTH = 6
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire logic [dskc_pkg::OPCODE_BITS-1:0]  i_opcode,
    input  wire logic [dskc_pkg::CHAR_BITS-1:0]    i_char_code,
    input  wire logic [dskc_pkg::INDEX_BITS-1:0]   i_read_index,
    output logic                                   o_push,
    output logic      [4*KMER_LENGTH:0]            o_entry
);

    import dskc_pkg::*;

    localparam int WIN_BITS   = 2 * KMER_LENGTH;
    localparam int VALID_BITS = $clog2(KMER_LENGTH + 1);
    localparam logic [VALID_BITS-1:0] FULL_VALID = VALID_BITS'(KMER_LENGTH);

    logic [WIN_BITS-1:0]   r_fwd, n_fwd;
    logic [WIN_BITS-1:0]   r_rev, n_rev;
    logic [VALID_BITS-1:0] r_valid, n_valid;
    t_base                 base;

    always_comb begin
        base    = base_decode(i_char_code);
        n_fwd   = r_fwd;
        n_rev   = r_rev;
        n_valid = r_valid;
        o_push  = 1'b0;
        o_entry = {CMD_COUNT, r_fwd, r_rev};
        if (i_accept) begin
            unique case (i_opcode)
                OP_CHAR: begin
                    if (base.hit) begin
                        // shift in: newest base low forward, complement high reverse
                        n_fwd   = WIN_BITS'({r_fwd, base.code});
                        n_rev   = WIN_BITS'({base.code ^ BASE_COMP, r_rev} >> 2);
                        n_valid = (r_valid == FULL_VALID) ? r_valid : r_valid + 1'b1;
                        o_push  = (n_valid == FULL_VALID);
                        o_entry = {CMD_COUNT, n_fwd, n_rev};
                    end else begin
                        n_fwd   = '0;
                        n_rev   = '0;
                        n_valid = '0;
                    end
                end
                OP_RECORD: begin
                    n_fwd   = '0;
                    n_rev   = '0;
                    n_valid = '0;
                end
                OP_READ: begin
                    o_push  = 1'b1;
                    o_entry = {CMD_READ, WIN_BITS'(i_read_index), {WIN_BITS{1'b0}}};
                end
                default: begin
                    // unused opcode: drop
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd   <= '0;
            r_rev   <= '0;
            r_valid <= '0;
        end else begin
            r_fwd   <= n_fwd;
            r_rev   <= n_rev;
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

### design/dskc_back.sv
// Back part: clears the tables after reset, then runs the saturating
// increments and the count reads. Depends on dskc_pkg and dskc_ram.
`default_nettype none

module dskc_back #(
    parameter int KMER_LENGTH = 6,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_valid,
    input  wire logic [4*KMER_LENGTH:0]          i_q_entry,
    output logic                                 o_q_pop,
    output logic                                 o_clearing,
    output logic                                 o_strobe,
    output logic      [dskc_pkg::OUT_BITS-1:0]   o_kmer_count,
    output logic      [dskc_pkg::OUT_BITS-1:0]   o_prefix_count
);

    import dskc_pkg::*;

    localparam int WIN_BITS = 2 * KMER_LENGTH;
    localparam int PFX_BITS = (KMER_LENGTH > 1) ? 2 * (KMER_LENGTH - 1) : 1;
    localparam int WIDE_BITS = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

    t_back_state          r_state, n_state;
    logic [WIN_BITS-1:0]  r_clr_addr;
    logic [WIN_BITS-1:0]  r_fwd, r_rev;
    logic [COUNT_BITS-1:0] r_kmer_b, r_pfx_b;

    t_cmd                 head_kind;
    logic [WIN_BITS-1:0]  head_fwd, head_rev;
    logic [PFX_BITS-1:0]  pfx_fwd, pfx_rev;
    logic [COUNT_BITS-1:0] k_rd_a, k_rd_b, p_rd_a, p_rd_b;
    logic [COUNT_BITS-1:0] k_new_a, k_new_b, p_new_a, p_new_b;
    logic                 k_same, p_same;

    logic                 k_we, p_we;
    logic [WIN_BITS-1:0]  k_waddr;
    logic [PFX_BITS-1:0]  p_waddr;
    logic [COUNT_BITS-1:0] k_wdata, p_wdata;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] v,
                                                      input logic two);
        logic [COUNT_BITS:0] s;
        s = {1'b0, v} + (COUNT_BITS + 1)'({two, ~two});
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [OUT_BITS-1:0] out_sat(input logic [COUNT_BITS-1:0] v);
        logic [WIDE_BITS-1:0] e;
        e = WIDE_BITS'(v);
        return (e > WIDE_BITS'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}} : e[OUT_BITS-1:0];
    endfunction

    assign head_kind = t_cmd'(i_q_entry[2*WIN_BITS]);
    assign head_fwd  = i_q_entry[2*WIN_BITS-1:WIN_BITS];
    assign head_rev  = i_q_entry[WIN_BITS-1:0];
    assign pfx_fwd   = PFX_BITS'(r_fwd >> 2);
    assign pfx_rev   = PFX_BITS'(r_rev >> 2);

    // Palindromes and coinciding prefixes hit one entry twice: add two once
    assign k_same  = (r_fwd == r_rev);
    assign p_same  = (pfx_fwd == pfx_rev);
    assign k_new_a = sat_add(k_rd_a, k_same);
    assign k_new_b = k_same ? k_new_a : sat_add(k_rd_b, 1'b0);
    assign p_new_a = sat_add(p_rd_a, p_same);
    assign p_new_b = p_same ? p_new_a : sat_add(p_rd_b, 1'b0);

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        k_we    = 1'b0;
        p_we    = 1'b0;
        k_waddr = r_fwd;
        p_waddr = pfx_fwd;
        k_wdata = k_new_a;
        p_wdata = p_new_a;
        unique case (r_state)
            S_CLEAR: begin
                k_we    = 1'b1;
                p_we    = 1'b1;
                k_waddr = r_clr_addr;
                p_waddr = PFX_BITS'(r_clr_addr);
                k_wdata = '0;
                p_wdata = '0;
                if (r_clr_addr == {WIN_BITS{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = (head_kind == CMD_READ) ? S_RDOUT : S_UPD1;
                end
            end
            S_UPD1: begin
                k_we    = 1'b1;
                p_we    = 1'b1;
                n_state = S_UPD2;
            end
            S_UPD2: begin
                k_we    = 1'b1;
                p_we    = 1'b1;
                k_waddr = r_rev;
                p_waddr = pfx_rev;
                k_wdata = r_kmer_b;
                p_wdata = r_pfx_b;
                n_state = S_IDLE;
            end
            S_RDOUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_fwd <= head_fwd;
            r_rev <= head_rev;
        end
        if (r_state == S_UPD1) begin
            r_kmer_b <= k_new_b;
            r_pfx_b  <= p_new_b;
        end
    end

    dskc_ram #(
        .DATA_BITS (COUNT_BITS),
        .ADDR_BITS (WIN_BITS)
    ) u_kmer_ram (
        .i_clk     (i_clk),
        .i_we      (k_we),
        .i_waddr   (k_waddr),
        .i_wdata   (k_wdata),
        .i_raddr_a (head_fwd),
        .i_raddr_b (head_rev),
        .o_rdata_a (k_rd_a),
        .o_rdata_b (k_rd_b)
    );

    dskc_ram #(
        .DATA_BITS (COUNT_BITS),
        .ADDR_BITS (PFX_BITS)
    ) u_prefix_ram (
        .i_clk     (i_clk),
        .i_we      (p_we),
        .i_waddr   (p_waddr),
        .i_wdata   (p_wdata),
        .i_raddr_a (PFX_BITS'(head_fwd >> 2)),
        .i_raddr_b (PFX_BITS'(head_rev >> 2)),
        .o_rdata_a (p_rd_a),
        .o_rdata_b (p_rd_b)
    );

    assign o_clearing     = (r_state == S_CLEAR);
    assign o_strobe       = (r_state == S_RDOUT);
    assign o_kmer_count   = out_sat(k_rd_a);
    assign o_prefix_count = out_sat(p_rd_a);

    a_upd_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD1 |=> r_state == S_UPD2)
        else $error("increment sequence broken after first write");

    a_read_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop && head_kind == CMD_READ |=> o_strobe)
        else $error("read command gave no result word");

endmodule

`default_nettype wire

### design/dual_strand_kmer_counter_top.sv
// Top level of the dual-strand k-mer counter: front part, command queue, back part.
// Depends on dskc_pkg, dskc_front, dskc_queue, dskc_back (and dskc_ram below it).
`default_nettype none

// Counts every k-mer of a DNA stream on both strands. Each input word is taken
// at a clock edge with start high and busy low. After reset the block sweeps both
// count tables to zero, one entry a cycle, and holds busy high all that time. Words
// that only move the windows (a base before K bases are valid, a non-base byte,
// record start) or are dropped (the unused opcode) finish in the front part. A
// counted base runs through the back part in steps (read both entries, write
// forward, write reverse, through the single write port of each table) and a read
// as a registered RAM read, then the result; a two-entry queue lets the front keep
// taking words meanwhile, and after the clear busy rises only when that queue is
// full. A read's result appears on strobe for exactly one cycle, in order behind
// all earlier counting; the receiver cannot hold it off, so take it then.
module dual_strand_kmer_counter_top #(
    parameter int KMER_LENGTH = 6,
    parameter int COUNT_BITS  = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [dskc_pkg::OPCODE_BITS-1:0]  i_opcode,
    input  wire logic [dskc_pkg::CHAR_BITS-1:0]    i_char_code,
    input  wire logic [dskc_pkg::INDEX_BITS-1:0]   i_read_index,
    output logic                                   strobe,
    output logic      [dskc_pkg::OUT_BITS-1:0]     o_kmer_count,
    output logic      [dskc_pkg::OUT_BITS-1:0]     o_prefix_count
);

    import dskc_pkg::*;

    // Queue word: command kind, forward window (or read index), reverse window
    localparam int ENTRY_BITS = 4 * KMER_LENGTH + 1;

    logic                  accept;
    logic                  push, pop;
    logic                  q_full, q_valid, clearing;
    logic [ENTRY_BITS-1:0] push_entry, head_entry;

    // Hold off new words while clearing or while the queue has no room
    assign busy   = q_full || clearing;
    assign accept = start && !busy;

    dskc_front #(
        .KMER_LENGTH (KMER_LENGTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_opcode     (i_opcode),
        .i_char_code  (i_char_code),
        .i_read_index (i_read_index),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    dskc_queue #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_entry)
    );

    dskc_back #(
        .KMER_LENGTH (KMER_LENGTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_entry      (head_entry),
        .o_q_pop        (pop),
        .o_clearing     (clearing),
        .o_strobe       (strobe),
        .o_kmer_count   (o_kmer_count),
        .o_prefix_count (o_prefix_count)
    );

endmodule

`default_nettype wire
